// ===== hw/rtl/nsp_pkg.sv =====
// Shared types, character codes and constants of the NMEA sentence parser.
// Used by the other files under hw/rtl except nsp_stream_if; depends on nothing.
package nsp_pkg;

    localparam int DEF_MAX_LINE       = 128;
    localparam int DEF_MAX_FIELDS     = 20;
    localparam int DEF_FRACTION_DIGITS = 5;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_W   = 8'h57;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    localparam logic [23:0] TAG_RMC = 24'h524D43;
    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_VTG = 24'h565447;
    localparam logic [6:0]  TYPE_CHARS = 7'd6;
    localparam logic [6:0]  CHARS_MAX  = 7'd127;

    localparam logic [30:0] RECIP_100 = 31'd1374389535;
    localparam logic [28:0] RECIP_15  = 29'h11111112;
    localparam logic [23:0] TEN_MILLION = 24'd10000000;
    localparam logic [31:0] COORD_CAP = 32'h7FFFFFFF;
    localparam logic [19:0] SPEED_CAP = 20'hFFFFF;
    localparam logic [15:0] HEAD_CAP  = 16'hFFFF;

    typedef enum logic [1:0] {LT_NONE, LT_RMC, LT_GGA, LT_VTG} t_line_type;
    typedef enum logic [2:0] {
        ST_RMC     = 3'd0,
        ST_GGA     = 3'd1,
        ST_VTG     = 3'd2,
        ST_BAD_SUM = 3'd3,
        ST_SKIP    = 3'd4
    } t_status;
    typedef enum logic [1:0] {PH_INT, PH_FRAC, PH_DONE} t_num_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         hours;
        logic [6:0]         minutes;
        logic [6:0]         seconds;
        logic               fix_valid;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [19:0]        speed_hundredths;
        logic [15:0]        heading_hundredths;
        logic [7:0]         fix_quality;
        logic [7:0]         satellites;
    } t_fix_word;

    typedef struct packed {
        logic       valid;
        logic       close;
        logic       fin;
        t_line_type ltype;
        logic [4:0] k;
        logic [7:0] first;
        t_status    status;
        logic [7:0] int_lo8;
    } t_evt_ctl;

    typedef struct packed {
        t_evt_ctl    ctl;
        logic [31:0] int_acc;
        logic [19:0] frac;
        logic [2:0]  fdig;
        logic [6:0]  h2;
    } t_field_event;

    typedef struct packed {
        t_evt_ctl    ctl;
        logic [7:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [49:0] degp;
        logic [25:0] minp;
        logic [38:0] h100;
    } t_conv_word;

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic t_line_type line_type_of(input logic [23:0] letters);
        t_line_type t;
        case (letters)
            TAG_RMC: t = LT_RMC;
            TAG_GGA: t = LT_GGA;
            TAG_VTG: t = LT_VTG;
            default: t = LT_NONE;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/nsp_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from nsp_pkg at instantiation.
interface nsp_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nsp_scan.sv =====
// Per-byte scanner: checksum, hex digits, field split and number accumulation.
// Emits a registered field event when a field closes or a line ends; depends on nsp_pkg.
module nsp_scan #(
    parameter int MAX_LINE        = nsp_pkg::DEF_MAX_LINE,
    parameter int MAX_FIELDS      = nsp_pkg::DEF_MAX_FIELDS,
    parameter int FRACTION_DIGITS = nsp_pkg::DEF_FRACTION_DIGITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_acc,
    input  logic [7:0]           i_byte,
    output nsp_pkg::t_field_event o_ev
);
    localparam int LW  = $clog2(MAX_LINE);
    localparam int FNW = $clog2(MAX_FIELDS);
    localparam int FW  = $clog2(nsp_pkg::pow10(FRACTION_DIGITS));

    logic [LW-1:0]  r_len, n_len;
    logic [7:0]     r_check, n_check;
    logic           r_star, n_star;
    logic [7:0]     r_hex, n_hex;
    logic           r_hexact, n_hexact;
    logic           r_closed, n_closed;
    logic [FNW-1:0] r_fnum, n_fnum;
    logic [6:0]     r_chars, n_chars;
    logic [23:0]    r_letters, n_letters;
    logic [31:0]    r_int, n_int;
    logic [FW-1:0]  r_frac, n_frac;
    logic [2:0]     r_fdig, n_fdig;
    nsp_pkg::t_num_phase r_phase, n_phase;
    logic [7:0]     r_first, n_first;
    logic [6:0]     r_h2, n_h2;
    nsp_pkg::t_field_event ev;
    nsp_pkg::t_line_type   ltype_end;
    logic [7:0]     c;
    logic           digit, hexok;
    logic [3:0]     dval, hval;
    logic [35:0]    int_ext;

    always_comb begin
        c       = i_byte;
        digit   = c inside {[nsp_pkg::CH_ZERO:nsp_pkg::CH_NINE]};
        dval    = 4'(c - nsp_pkg::CH_ZERO);
        hexok   = 1'b1;
        hval    = dval;
        if (c inside {[nsp_pkg::CH_UP_A:nsp_pkg::CH_UP_F]}) begin
            hval = 4'(c - nsp_pkg::CH_UP_A + 8'd10);
        end else if (c inside {[nsp_pkg::CH_LOW_A:nsp_pkg::CH_LOW_F]}) begin
            hval = 4'(c - nsp_pkg::CH_LOW_A + 8'd10);
        end else if (!digit) begin
            hexok = 1'b0;
        end
        int_ext = {4'd0, r_int} * 36'd10 + 36'(dval);

        n_len = r_len; n_check = r_check; n_star = r_star; n_hex = r_hex;
        n_hexact = r_hexact; n_closed = r_closed; n_fnum = r_fnum; n_chars = r_chars;
        n_letters = r_letters; n_int = r_int; n_frac = r_frac; n_fdig = r_fdig;
        n_phase = r_phase; n_first = r_first; n_h2 = r_h2;

        ev             = '0;
        ev.ctl.k       = 5'(r_fnum);
        ev.ctl.ltype   = nsp_pkg::line_type_of(r_letters);
        ev.ctl.first   = r_first;
        ev.ctl.int_lo8 = r_int[7:0];
        ev.ctl.status  = nsp_pkg::ST_SKIP;
        ev.int_acc     = r_int;
        ev.frac        = 20'(r_frac);
        ev.fdig        = r_fdig;
        ev.h2          = r_h2;
        ltype_end      = ev.ctl.ltype;

        if (i_acc) begin
            if (c == nsp_pkg::CH_LF) begin
                ev.ctl.valid = 1'b1;
                ev.ctl.fin   = 1'b1;
                ev.ctl.close = !r_closed;
                if (!r_closed && r_fnum == '0 && r_chars != nsp_pkg::TYPE_CHARS) begin
                    ltype_end = nsp_pkg::LT_NONE;
                end
                if (r_star && r_check != r_hex) begin
                    ev.ctl.status = nsp_pkg::ST_BAD_SUM;
                end else if (ltype_end == nsp_pkg::LT_RMC && r_fnum >= FNW'(8)) begin
                    ev.ctl.status = nsp_pkg::ST_RMC;
                end else if (ltype_end == nsp_pkg::LT_GGA && r_fnum >= FNW'(7)) begin
                    ev.ctl.status = nsp_pkg::ST_GGA;
                end else if (ltype_end == nsp_pkg::LT_VTG && r_fnum >= FNW'(7)) begin
                    ev.ctl.status = nsp_pkg::ST_VTG;
                end
                n_len = '0; n_check = '0; n_star = 1'b0; n_hex = '0; n_hexact = 1'b0;
                n_closed = 1'b0; n_fnum = '0; n_chars = '0; n_letters = '0; n_int = '0;
                n_frac = '0; n_fdig = '0; n_phase = nsp_pkg::PH_INT; n_first = '0;
                n_h2 = '0;
            end else if (r_len < LW'(MAX_LINE - 1)) begin
                if (!r_star && !(r_len == '0 && c == nsp_pkg::CH_DOLLAR)
                        && c != nsp_pkg::CH_STAR) begin
                    n_check = r_check ^ c;
                end
                if (c == nsp_pkg::CH_STAR) begin
                    n_star = 1'b1; n_hexact = 1'b1; n_hex = '0;
                end else if (r_hexact) begin
                    if (hexok) begin
                        n_hex = {r_hex[3:0], hval};
                    end else begin
                        n_hexact = 1'b0;
                    end
                end
                if (!r_closed) begin
                    if (c == nsp_pkg::CH_STAR || c == nsp_pkg::CH_CR
                            || (c == nsp_pkg::CH_COMMA && r_fnum < FNW'(MAX_FIELDS - 1))) begin
                        ev.ctl.valid = 1'b1;
                        ev.ctl.close = 1'b1;
                        if (r_fnum == '0 && r_chars != nsp_pkg::TYPE_CHARS) begin
                            n_letters = '0;
                        end
                        if (c == nsp_pkg::CH_COMMA) begin
                            n_fnum = r_fnum + 1'b1;
                        end else begin
                            n_closed = 1'b1;
                        end
                        n_chars = '0; n_first = '0; n_int = '0; n_frac = '0; n_fdig = '0;
                        n_phase = nsp_pkg::PH_INT; n_h2 = '0;
                    end else begin
                        if (r_chars == '0) begin
                            n_first = c;
                        end
                        if (r_chars != nsp_pkg::CHARS_MAX) begin
                            n_chars = r_chars + 1'b1;
                        end
                        if (r_fnum == '0) begin
                            n_letters = {r_letters[15:0], c};
                        end
                        case (r_phase)
                            nsp_pkg::PH_INT: begin
                                if (digit) begin
                                    n_int = (int_ext[35:32] != '0) ? '1 : int_ext[31:0];
                                end else begin
                                    n_phase = (c == nsp_pkg::CH_DOT) ? nsp_pkg::PH_FRAC
                                                                     : nsp_pkg::PH_DONE;
                                end
                            end
                            nsp_pkg::PH_FRAC: begin
                                if (digit) begin
                                    if (r_fdig < 3'(FRACTION_DIGITS)) begin
                                        n_frac = FW'(r_frac * FW'(10) + FW'(dval));
                                        n_fdig = r_fdig + 1'b1;
                                        if (r_fdig < 3'd2) begin
                                            n_h2 = 7'(r_h2 * 7'd10 + 7'(dval));
                                        end
                                    end
                                end else begin
                                    n_phase = nsp_pkg::PH_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                n_len = r_len + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_check <= '0; r_star <= 1'b0; r_hex <= '0; r_hexact <= 1'b0;
            r_closed <= 1'b0; r_fnum <= '0; r_chars <= '0; r_letters <= '0; r_int <= '0;
            r_frac <= '0; r_fdig <= '0; r_phase <= nsp_pkg::PH_INT; r_first <= '0;
            r_h2 <= '0; o_ev <= '0;
        end else if (i_en) begin
            r_len <= n_len; r_check <= n_check; r_star <= n_star; r_hex <= n_hex;
            r_hexact <= n_hexact; r_closed <= n_closed; r_fnum <= n_fnum;
            r_chars <= n_chars; r_letters <= n_letters; r_int <= n_int; r_frac <= n_frac;
            r_fdig <= n_fdig; r_phase <= n_phase; r_first <= n_first; r_h2 <= n_h2;
            o_ev <= ev;
        end
    end
endmodule

// ===== hw/rtl/nsp_conv.sv =====
// Four-stage fixed-point conversion of a closed field: time split, coordinate
// degrees-minutes to 1e-7 degrees, hundredths. Depends on nsp_pkg.
module nsp_conv #(
    parameter int FRACTION_DIGITS = nsp_pkg::DEF_FRACTION_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  nsp_pkg::t_field_event i_ev,
    output nsp_pkg::t_conv_word   o_cw
);
    localparam logic [33:0] MIN_SCALE = 34'(nsp_pkg::pow10(7 - FRACTION_DIGITS));

    typedef struct packed {
        nsp_pkg::t_evt_ctl ctl;
        logic [31:0] int_acc;
        logic [60:0] p1;
        logic [19:0] fs;
        logic [38:0] h100;
    } t_s1;

    typedef struct packed {
        nsp_pkg::t_evt_ctl ctl;
        logic [25:0] q1;
        logic [6:0]  r1;
        logic [54:0] p2;
        logic [19:0] fs;
        logic [38:0] h100;
    } t_s2;

    typedef struct packed {
        nsp_pkg::t_evt_ctl ctl;
        logic [7:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [29:0] x;
        logic [49:0] degp;
        logic [38:0] h100;
    } t_s3;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    nsp_pkg::t_conv_word n_cw;
    logic [19:0] scale;
    logic [38:0] h2pad;
    logic [18:0] q2;
    logic [57:0] p3;

    always_comb begin
        scale = 20'(nsp_pkg::pow10(FRACTION_DIGITS));
        for (int i = 1; i <= 6; i++) begin
            if (i_ev.fdig == 3'(i)) begin
                scale = 20'(nsp_pkg::pow10(FRACTION_DIGITS - i));
            end
        end
        case (i_ev.fdig)
            3'd0:    h2pad = '0;
            3'd1:    h2pad = 39'(i_ev.h2) * 39'd10;
            default: h2pad = 39'(i_ev.h2);
        endcase
        n_s1.ctl     = i_ev.ctl;
        n_s1.int_acc = i_ev.int_acc;
        n_s1.p1      = 61'(i_ev.int_acc[31:2]) * 61'(nsp_pkg::RECIP_100);
        n_s1.fs      = 20'(i_ev.frac * scale);
        n_s1.h100    = 39'(i_ev.int_acc) * 39'd100 + h2pad;

        n_s2.ctl  = r_s1.ctl;
        n_s2.q1   = r_s1.p1[60:35];
        n_s2.r1   = 7'(r_s1.int_acc - 32'(r_s1.p1[60:35]) * 32'd100);
        n_s2.p2   = 55'(r_s1.p1[60:37]) * 55'(nsp_pkg::RECIP_100);
        n_s2.fs   = r_s1.fs;
        n_s2.h100 = r_s1.h100;

        q2           = r_s2.p2[53:35];
        n_s3.ctl     = r_s2.ctl;
        n_s3.hours   = q2[7:0];
        n_s3.minutes = 7'(r_s2.q1 - 26'(q2) * 26'd100);
        n_s3.seconds = r_s2.r1;
        n_s3.x       = 30'(34'(r_s2.r1) * 34'(nsp_pkg::TEN_MILLION)
                         + 34'(r_s2.fs) * MIN_SCALE);
        n_s3.degp    = 50'(r_s2.q1) * 50'(nsp_pkg::TEN_MILLION);
        n_s3.h100    = r_s2.h100;

        p3           = 58'(r_s3.x[29:2]) * 58'(nsp_pkg::RECIP_15);
        n_cw.ctl     = r_s3.ctl;
        n_cw.hours   = r_s3.hours;
        n_cw.minutes = r_s3.minutes;
        n_cw.seconds = r_s3.seconds;
        n_cw.degp    = r_s3.degp;
        n_cw.minp    = p3[57:32];
        n_cw.h100    = r_s3.h100;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.ctl <= '0;
            r_s2.ctl <= '0;
            r_s3.ctl <= '0;
            o_cw.ctl <= '0;
        end else if (i_en) begin
            r_s1.ctl <= n_s1.ctl;
            r_s2.ctl <= n_s2.ctl;
            r_s3.ctl <= n_s3.ctl;
            o_cw.ctl <= n_cw.ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.int_acc <= n_s1.int_acc; r_s1.p1 <= n_s1.p1; r_s1.fs <= n_s1.fs;
            r_s1.h100 <= n_s1.h100;
            r_s2.q1 <= n_s2.q1; r_s2.r1 <= n_s2.r1; r_s2.p2 <= n_s2.p2;
            r_s2.fs <= n_s2.fs; r_s2.h100 <= n_s2.h100;
            r_s3.hours <= n_s3.hours; r_s3.minutes <= n_s3.minutes;
            r_s3.seconds <= n_s3.seconds; r_s3.x <= n_s3.x; r_s3.degp <= n_s3.degp;
            r_s3.h100 <= n_s3.h100;
            o_cw.hours <= n_cw.hours; o_cw.minutes <= n_cw.minutes;
            o_cw.seconds <= n_cw.seconds; o_cw.degp <= n_cw.degp;
            o_cw.minp <= n_cw.minp; o_cw.h100 <= n_cw.h100;
        end
    end
endmodule

// ===== hw/rtl/nsp_record.sv =====
// Staged and stored fix: applies converted fields, commits at line end and
// holds the output record register. Depends on nsp_pkg and nsp_stream_if.
module nsp_record (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  nsp_pkg::t_conv_word i_cw,
    nsp_stream_if.source        o_fix
);
    nsp_pkg::t_fix_word r_st, n_st;
    nsp_pkg::t_fix_word r_fix, n_fix;
    nsp_pkg::t_fix_word r_out, n_out;
    logic               r_ovalid;
    logic [50:0]        sum;
    logic [31:0]        mag;
    logic [19:0]        spd;
    logic [15:0]        hdg;
    logic               neg;

    always_comb begin
        sum = 51'(i_cw.degp) + 51'(i_cw.minp);
        mag = (sum > 51'(nsp_pkg::COORD_CAP)) ? nsp_pkg::COORD_CAP : sum[31:0];
        spd = (i_cw.h100 > 39'(nsp_pkg::SPEED_CAP)) ? nsp_pkg::SPEED_CAP : i_cw.h100[19:0];
        hdg = (i_cw.h100 > 39'(nsp_pkg::HEAD_CAP)) ? nsp_pkg::HEAD_CAP : i_cw.h100[15:0];
        neg = i_cw.ctl.first == nsp_pkg::CH_UP_S || i_cw.ctl.first == nsp_pkg::CH_UP_W;
        n_st  = r_st;
        n_fix = r_fix;
        n_out = r_out;
        if (i_cw.ctl.valid && i_cw.ctl.close) begin
            case (i_cw.ctl.ltype)
                nsp_pkg::LT_RMC: begin
                    case (i_cw.ctl.k)
                        5'd1: begin
                            n_st.hours = i_cw.hours; n_st.minutes = i_cw.minutes;
                            n_st.seconds = i_cw.seconds;
                        end
                        5'd2: n_st.fix_valid = i_cw.ctl.first == nsp_pkg::CH_UP_A;
                        5'd3: n_st.latitude = mag;
                        5'd4: if (neg) n_st.latitude = -r_st.latitude;
                        5'd5: n_st.longitude = mag;
                        5'd6: if (neg) n_st.longitude = -r_st.longitude;
                        5'd7: n_st.speed_hundredths = spd;
                        5'd8: n_st.heading_hundredths = hdg;
                        default: ;
                    endcase
                end
                nsp_pkg::LT_GGA: begin
                    case (i_cw.ctl.k)
                        5'd1: begin
                            n_st.hours = i_cw.hours; n_st.minutes = i_cw.minutes;
                            n_st.seconds = i_cw.seconds;
                        end
                        5'd2: n_st.latitude = mag;
                        5'd3: if (neg) n_st.latitude = -r_st.latitude;
                        5'd4: n_st.longitude = mag;
                        5'd5: if (neg) n_st.longitude = -r_st.longitude;
                        5'd6: n_st.fix_quality = i_cw.ctl.int_lo8;
                        5'd7: n_st.satellites = i_cw.ctl.int_lo8;
                        default: ;
                    endcase
                end
                nsp_pkg::LT_VTG: begin
                    case (i_cw.ctl.k)
                        5'd1: n_st.heading_hundredths = hdg;
                        5'd5: n_st.speed_hundredths = spd;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (i_cw.ctl.valid && i_cw.ctl.fin) begin
            case (i_cw.ctl.status)
                nsp_pkg::ST_RMC: begin
                    n_fix.latitude = n_st.latitude; n_fix.longitude = n_st.longitude;
                    n_fix.speed_hundredths = n_st.speed_hundredths;
                    n_fix.heading_hundredths = n_st.heading_hundredths;
                    n_fix.hours = n_st.hours; n_fix.minutes = n_st.minutes;
                    n_fix.seconds = n_st.seconds; n_fix.fix_valid = n_st.fix_valid;
                end
                nsp_pkg::ST_GGA: begin
                    n_fix.latitude = n_st.latitude; n_fix.longitude = n_st.longitude;
                    n_fix.hours = n_st.hours; n_fix.minutes = n_st.minutes;
                    n_fix.seconds = n_st.seconds; n_fix.fix_quality = n_st.fix_quality;
                    n_fix.satellites = n_st.satellites;
                end
                nsp_pkg::ST_VTG: begin
                    n_fix.speed_hundredths = n_st.speed_hundredths;
                    n_fix.heading_hundredths = n_st.heading_hundredths;
                end
                default: ;
            endcase
            n_out        = n_fix;
            n_out.status = i_cw.ctl.status;
            n_st         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '0;
            r_fix    <= '0;
            r_ovalid <= 1'b0;
        end else if (i_en) begin
            r_st     <= n_st;
            r_fix    <= n_fix;
            r_ovalid <= i_cw.ctl.valid && i_cw.ctl.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_fix.valid = r_ovalid;
    assign o_fix.data  = r_out;
endmodule

// ===== hw/rtl/nmea_sentence_parser_top.sv =====
// NMEA 0183 RMC/GGA/VTG parser: one byte word in per cycle, one fix record out per LF.
// After its LF, a line's record passes nsp_scan, nsp_conv and nsp_record registers.
// Throughput: one byte per cycle; the whole pipeline holds only while o_fix stalls.
// Reset (synchronous, active low) clears line state, the stored fix and o_fix.valid.
// Depends on nsp_pkg, nsp_stream_if, nsp_scan, nsp_conv and nsp_record.
module nmea_sentence_parser_top #(
    parameter int MAX_LINE        = nsp_pkg::DEF_MAX_LINE,
    parameter int MAX_FIELDS      = nsp_pkg::DEF_MAX_FIELDS,
    parameter int FRACTION_DIGITS = nsp_pkg::DEF_FRACTION_DIGITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nsp_stream_if.sink   i_rx,
    nsp_stream_if.source o_fix
);
    logic                  en;
    nsp_pkg::t_field_event ev;
    nsp_pkg::t_conv_word   cw;

    assign en         = !o_fix.valid || o_fix.ready;
    assign i_rx.ready = en;

    nsp_scan #(
        .MAX_LINE(MAX_LINE),
        .MAX_FIELDS(MAX_FIELDS),
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_scan (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_acc(i_rx.valid && en),
        .i_byte(i_rx.data.rx_byte),
        .o_ev(ev)
    );

    nsp_conv #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_conv (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_ev(ev),
        .o_cw(cw)
    );

    nsp_record u_record (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_cw(cw),
        .o_fix(o_fix)
    );

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx.ready == (!o_fix.valid || o_fix.ready))
        else $error("input ready does not follow output stall");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_fix.valid)
        else $error("output valid after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fix.valid |-> (o_fix.data.status == nsp_pkg::ST_RMC
            || o_fix.data.status == nsp_pkg::ST_GGA || o_fix.data.status == nsp_pkg::ST_VTG
            || o_fix.data.status == nsp_pkg::ST_BAD_SUM
            || o_fix.data.status == nsp_pkg::ST_SKIP))
        else $error("status code out of range");
endmodule

// ===== test/nmea_sentence_parser_top_tb.sv =====
// Self-checking testbench of nmea_sentence_parser_top: drives NMEA byte words and
// compares every fix record against an in-bench model of the parser.
// Depends on nsp_pkg, nsp_stream_if and the parser RTL.
module nmea_sentence_parser_top_tb;
    import nsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT  = DEF_MAX_LINE;
    localparam int FIELD_LIMIT = DEF_MAX_FIELDS;
    localparam int FDIGITS     = DEF_FRACTION_DIGITS;

    logic i_clk;
    logic i_rst_n;

    nsp_stream_if #(.t_payload(t_rx_word)) rx_ch ();
    nsp_stream_if #(.t_payload(t_fix_word)) fix_ch ();

    nmea_sentence_parser_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_ch.sink),
        .o_fix  (fix_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // parser state
    int unsigned      p_len, p_sum, p_star, p_hex, p_hex_on, p_closed, p_fld, p_chars;
    int unsigned      p_tag, p_int, p_frac, p_fdig, p_phase, p_first;
    longint unsigned  p_stage_pos, p_stage_oth, p_pos, p_mot, p_tq;

    t_fix_word        fix_expected[$];
    logic [7:0]       byte_queue[$];
    int               fail_count;
    int               send_idle_pct, recv_idle_pct;
    bit               stim_done;

    function automatic longint unsigned put_f(longint unsigned w, int pos, int width,
                                              longint unsigned v);
        longint unsigned m;
        m = ((64'd1 << width) - 1) << pos;
        return (w & ~m) | ((v << pos) & m);
    endfunction

    function automatic longint unsigned get_f(longint unsigned w, int pos, int width);
        return (w >> pos) & ((64'd1 << width) - 1);
    endfunction

    function automatic longint unsigned ten_pow(int n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < n; i++) r = r * 10;
        return r;
    endfunction

    function automatic longint unsigned frac_scaled();
        return longint'(p_frac) * ten_pow(FDIGITS - p_fdig);
    endfunction

    function automatic longint unsigned to_hundredths(longint unsigned cap);
        longint unsigned v;
        v = longint'(p_int) * 100 + frac_scaled() * 100 / ten_pow(FDIGITS);
        return v > cap ? cap : v;
    endfunction

    function automatic longint unsigned coord_mag();
        longint unsigned pp, deg, mins, v;
        pp = ten_pow(FDIGITS);
        deg = p_int / 100;
        mins = longint'(p_int % 100) * pp + frac_scaled();
        v = deg * 10000000 + mins * 10000000 / (60 * pp);
        return v > 64'h7FFFFFFF ? 64'h7FFFFFFF : v;
    endfunction

    function automatic t_line_type kind_now();
        return line_type_of(p_tag[23:0]);
    endfunction

    function automatic void stage_time();
        p_stage_oth = put_f(p_stage_oth, 0, 7, p_int % 100);
        p_stage_oth = put_f(p_stage_oth, 7, 7, (p_int / 100) % 100);
        p_stage_oth = put_f(p_stage_oth, 14, 8, (p_int / 10000) & 8'hFF);
    endfunction

    function automatic void stage_hemi(int pos);
        longint unsigned v;
        if (p_first == CH_UP_S || p_first == CH_UP_W) begin
            v = get_f(p_stage_pos, pos, 32);
            p_stage_pos = put_f(p_stage_pos, pos, 32, (64'd0 - v) & 64'hFFFFFFFF);
        end
    endfunction

    function automatic void close_field();
        t_line_type t;
        t = kind_now();
        if (p_fld == 0) begin
            if (p_chars != 6) p_tag = 0;
        end else if (t == LT_RMC) begin
            case (p_fld)
                1: stage_time();
                2: p_stage_oth = put_f(p_stage_oth, 22, 1, p_first == CH_UP_A);
                3: p_stage_pos = put_f(p_stage_pos, 0, 32, coord_mag());
                4: stage_hemi(0);
                5: p_stage_pos = put_f(p_stage_pos, 32, 32, coord_mag());
                6: stage_hemi(32);
                7: p_stage_oth = put_f(p_stage_oth, 23, 20, to_hundredths(20'hFFFFF));
                8: p_stage_oth = put_f(p_stage_oth, 43, 16, to_hundredths(16'hFFFF));
                default: ;
            endcase
        end else if (t == LT_GGA) begin
            case (p_fld)
                1: stage_time();
                2: p_stage_pos = put_f(p_stage_pos, 0, 32, coord_mag());
                3: stage_hemi(0);
                4: p_stage_pos = put_f(p_stage_pos, 32, 32, coord_mag());
                5: stage_hemi(32);
                6: p_stage_oth = put_f(p_stage_oth, 23, 8, p_int & 8'hFF);
                7: p_stage_oth = put_f(p_stage_oth, 31, 8, p_int & 8'hFF);
                default: ;
            endcase
        end else if (t == LT_VTG) begin
            if (p_fld == 1)
                p_stage_oth = put_f(p_stage_oth, 43, 16, to_hundredths(16'hFFFF));
            else if (p_fld == 5)
                p_stage_oth = put_f(p_stage_oth, 23, 20, to_hundredths(20'hFFFFF));
        end
        p_chars = 0; p_first = 0; p_int = 0; p_frac = 0; p_fdig = 0; p_phase = 0;
    endfunction

    function automatic void field_char(int unsigned c);
        bit is_dig;
        longint unsigned v;
        is_dig = c >= CH_ZERO && c <= CH_NINE;
        if (p_chars == 0) p_first = c;
        if (p_chars < 127) p_chars++;
        if (p_fld == 0) p_tag = ((p_tag << 8) | c) & 24'hFFFFFF;
        if (p_phase == 0) begin
            if (is_dig) begin
                v = longint'(p_int) * 10 + (c - CH_ZERO);
                p_int = v > 64'hFFFFFFFF ? 32'hFFFFFFFF : v[31:0];
            end else begin
                p_phase = (c == CH_DOT) ? 1 : 2;
            end
        end else if (p_phase == 1) begin
            if (is_dig) begin
                if (p_fdig < FDIGITS) begin
                    p_frac = p_frac * 10 + (c - CH_ZERO);
                    p_fdig++;
                end
            end else begin
                p_phase = 2;
            end
        end
    endfunction

    function automatic void clear_line();
        p_len = 0; p_sum = 0; p_star = 0; p_hex = 0; p_hex_on = 0; p_closed = 0;
        p_fld = 0; p_chars = 0; p_tag = 0; p_int = 0; p_frac = 0; p_fdig = 0;
        p_phase = 0; p_first = 0; p_stage_pos = 0; p_stage_oth = 0;
    endfunction

    function automatic void finish_line();
        t_fix_word f;
        t_status st;
        int unsigned n;
        t_line_type t;
        if (!p_closed) begin
            close_field();
            p_closed = 1;
        end
        n = p_fld + 1;
        t = kind_now();
        st = ST_SKIP;
        if (p_star && p_sum != p_hex) begin
            st = ST_BAD_SUM;
        end else if (t == LT_RMC && n >= 9) begin
            st = ST_RMC;
            p_pos = p_stage_pos;
            p_mot = put_f(p_mot, 0, 20, get_f(p_stage_oth, 23, 20));
            p_mot = put_f(p_mot, 20, 16, get_f(p_stage_oth, 43, 16));
            p_tq = put_f(p_tq, 0, 23, get_f(p_stage_oth, 0, 23));
        end else if (t == LT_GGA && n >= 8) begin
            st = ST_GGA;
            p_pos = p_stage_pos;
            p_tq = put_f(p_tq, 0, 22, get_f(p_stage_oth, 0, 22));
            p_tq = put_f(p_tq, 23, 16, get_f(p_stage_oth, 23, 16));
        end else if (t == LT_VTG && n >= 8) begin
            st = ST_VTG;
            p_mot = put_f(p_mot, 0, 20, get_f(p_stage_oth, 23, 20));
            p_mot = put_f(p_mot, 20, 16, get_f(p_stage_oth, 43, 16));
        end
        f.status             = st;
        f.hours              = get_f(p_tq, 14, 8);
        f.minutes            = get_f(p_tq, 7, 7);
        f.seconds            = get_f(p_tq, 0, 7);
        f.fix_valid          = get_f(p_tq, 22, 1);
        f.latitude           = get_f(p_pos, 0, 32);
        f.longitude          = get_f(p_pos, 32, 32);
        f.speed_hundredths   = get_f(p_mot, 0, 20);
        f.heading_hundredths = get_f(p_mot, 20, 16);
        f.fix_quality        = get_f(p_tq, 23, 8);
        f.satellites         = get_f(p_tq, 31, 8);
        fix_expected.push_back(f);
        clear_line();
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        int unsigned d;
        if (c == CH_LF) begin
            finish_line();
            return;
        end
        if (p_len >= LINE_LIMIT - 1) return;
        if (!p_star && !(p_len == 0 && c == CH_DOLLAR) && c != CH_STAR) p_sum ^= c;
        if (c == CH_STAR) begin
            p_star = 1; p_hex_on = 1; p_hex = 0;
        end else if (p_hex_on) begin
            d = 16;
            if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
            else if (c >= CH_UP_A && c <= CH_UP_F) d = c - CH_UP_A + 10;
            else if (c >= CH_LOW_A && c <= CH_LOW_F) d = c - CH_LOW_A + 10;
            if (d < 16) p_hex = ((p_hex << 4) | d) & 8'hFF;
            else p_hex_on = 0;
        end
        if (!p_closed) begin
            if (c == CH_STAR || c == CH_CR) begin
                close_field();
                p_closed = 1;
            end else if (c == CH_COMMA && p_fld < FIELD_LIMIT - 1) begin
                close_field();
                p_fld++;
            end else begin
                field_char(c);
            end
        end
        p_len++;
    endfunction

    // stimulus builders
    function automatic string rand_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'(CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_number(int ilen, int flen);
        string s;
        s = rand_digits(ilen);
        if (flen > 0) s = {s, ".", rand_digits(flen)};
        return s;
    endfunction

    function automatic string hex2(logic [7:0] v);
        return $sformatf("%02X", v);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
    endfunction

    function automatic void push_sentence(string body, int mode);
        logic [7:0] cs;
        cs = 0;
        for (int i = 0; i < body.len(); i++) cs ^= body[i];
        if (mode == 1) cs ^= 8'h01;
        if (mode == 2) push_text({"$", body, "\r\n"});
        else if (mode == 3) push_text({"$", body, "*", $sformatf("%02x", cs), "\n"});
        else push_text({"$", body, "*", hex2(cs), "\r\n"});
    endfunction

    function automatic string rand_rmc();
        return {"GP", "RMC,", rand_number(6, $urandom_range(0, 3)), ",",
                ($urandom_range(0, 1) ? "A" : "V"), ",",
                rand_number($urandom_range(3, 5), $urandom_range(0, 7)), ",",
                ($urandom_range(0, 1) ? "N" : "S"), ",",
                rand_number($urandom_range(4, 6), $urandom_range(0, 6)), ",",
                ($urandom_range(0, 1) ? "E" : "W"), ",",
                rand_number($urandom_range(1, 7), $urandom_range(0, 3)), ",",
                rand_number($urandom_range(1, 4), $urandom_range(0, 3)), ",",
                rand_digits(6), ",,"};
    endfunction

    function automatic string rand_gga();
        return {"GN", "GGA,", rand_number(6, 2), ",",
                rand_number($urandom_range(3, 10), $urandom_range(0, 5)), ",",
                ($urandom_range(0, 1) ? "N" : "S"), ",",
                rand_number($urandom_range(4, 6), $urandom_range(0, 5)), ",",
                ($urandom_range(0, 1) ? "E" : "W"), ",",
                rand_digits($urandom_range(1, 3)), ",",
                rand_digits($urandom_range(1, 3)), ",0.9,545.4,M,46.9,M,,"};
    endfunction

    function automatic string rand_vtg();
        return {"GP", "VTG,", rand_number($urandom_range(1, 5), $urandom_range(0, 6)),
                ",T,,M,", rand_number($urandom_range(1, 3), $urandom_range(0, 3)),
                ",N,", rand_number(2, 1), ",K"};
    endfunction

    function automatic void push_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) byte_queue.push_back($urandom_range(0, 255));
        byte_queue.push_back(CH_LF);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (!rx_ch.valid || rx_ch.ready) begin
            if (rx_ch.valid) parse_byte(rx_ch.data.rx_byte);
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rx_ch.valid        <= 1'b1;
                rx_ch.data.rx_byte <= byte_queue.pop_front();
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_fix_word want;
        if (!i_rst_n) begin
            fix_ch.ready <= 1'b0;
        end else begin
            if (fix_ch.valid && fix_ch.ready) begin
                if (fix_expected.size() == 0) begin
                    $display("%0t: unexpected fix word %p", $time, fix_ch.data);
                    fail_count++;
                end else begin
                    want = fix_expected.pop_front();
                    if (want !== fix_ch.data) begin
                        $display("%0t: fix mismatch expected %p actual %p",
                                 $time, want, fix_ch.data);
                        fail_count++;
                    end
                end
            end
            fix_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic drain();
        while (byte_queue.size() > 0 || rx_ch.valid) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        while (fix_expected.size() > 0) @(posedge i_clk);
    endtask

    function automatic void random_batch(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) push_sentence(rand_rmc(), $urandom_range(0, 9) == 0);
            else if (pick < 55) push_sentence(rand_gga(), $urandom_range(0, 9) == 0 ? 1 : 3);
            else if (pick < 75) push_sentence(rand_vtg(), $urandom_range(0, 3) == 0 ? 2 : 0);
            else if (pick < 88) push_noise();
            else push_sentence({"GPRMC,", rand_digits($urandom_range(0, 6)), ",A"}, 0);
        end
    endfunction

    initial begin
        string s;
        fail_count    = 0;
        stim_done     = 0;
        send_idle_pct = 19;
        recv_idle_pct = 65;
        rx_ch.valid   = 1'b0;
        rx_ch.data    = '0;
        fix_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        p_pos = 0; p_mot = 0; p_tq = 0;
        clear_line();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        byte_queue.push_back(CH_LF);
        push_sentence("GPRMC,235959.99,A,8959.99999,S,17959.99999,W,99999.99,359.99,311299,,", 0);
        push_sentence("GPRMC,000000,V,0000.0,N,00000.0,E,0,0,010100", 0);
        push_sentence("GNGGA,123456,9999.9999999,N,99999.99999,E,255,300,1,2,M", 0);
        push_sentence("GPVTG,654.329,T,,M,12345.678,N,1,K", 2);
        push_sentence("GPRMC,1,A,1,N,1,E,1,1", 1);
        push_sentence("RMC,1,A,1,N,1,E,1,1,1", 0);
        push_sentence("GPGSV,1,2,3", 0);
        push_sentence("GPRMC,99999999999,A,-12,S, 5,W,1e3,x,", 0);
        push_text("$GPVTG,1,2,3,4,5,6,7*00*12*\r\n");
        push_text("$GPRMC,1,A,2,N,3,E,4,5*ZZ\n");
        s = "GPGGA";
        for (int i = 0; i < 25; i++) s = {s, ",9"};
        push_sentence(s, 0);
        s = "GPRMC,1";
        for (int i = 0; i < 150; i++) s = {s, "7"};
        push_text({"$", s, "\n"});
        for (int v = 0; v < 256; v += 37) byte_queue.push_back(v);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(CH_LF);
        drain();

        random_batch(70);
        drain();
        send_idle_pct = 65;
        recv_idle_pct = 19;
        random_batch(70);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_batch(70);
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && fix_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_stream_if.sv
hw/rtl/nsp_scan.sv
hw/rtl/nsp_conv.sv
hw/rtl/nsp_record.sv
hw/rtl/nmea_sentence_parser_top.sv
test/nmea_sentence_parser_top_tb.sv
